/* rtl/lfp_pkg.sv */
// Shared result codes, register indexes and result word type for the field parser.
package lfp_pkg;

  localparam logic [1:0] KIND_INT     = 2'd0;
  localparam logic [1:0] KIND_HEADER  = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  localparam logic [2:0] ERR_NEGATIVE     = 3'd0;
  localparam logic [2:0] ERR_TOO_LONG     = 3'd1;
  localparam logic [2:0] ERR_NO_DATA      = 3'd2;
  localparam logic [2:0] ERR_NOT_MULTIPLE = 3'd3;
  localparam logic [2:0] ERR_OVERRUN      = 3'd4;

  localparam logic [1:0] REG_FIELD_MODE   = 2'd0;
  localparam logic [1:0] REG_MAX_LENGTH   = 2'd1;
  localparam logic [1:0] REG_ELEMENT_SIZE = 2'd2;
  localparam logic [1:0] REG_STREAM_SIZE  = 2'd3;

  localparam logic [30:0] MAX_LENGTH_RESET = 31'd1048576;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic [7:0]  pbyte;
    logic [2:0]  code;
    logic        last;
  } result_t;

endpackage

/* rtl/length_prefixed_field_parser.sv */
// Top level of the signed varint and length-prefixed field parser.
// A byte of the stream is taken whenever the parser is idle and the output register is
// free or being emptied, so integer fields and payload bytes run at one word per cycle
// while the output is not stalled. The last prefix byte of a buffer field is taken,
// then the sign, maximum and remaining-data checks run, then 32 steps of the one-bit
// restoring divider yield the element count and the remainder, and then the header is
// issued; no word is taken meanwhile. The first error is issued once and the block
// then drops every further word until reset.
module length_prefixed_field_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_result_kind,
  output logic signed [31:0] out_value,
  output logic [7:0]         out_payload_byte,
  output logic [2:0]         out_error_code,
  output logic               out_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic        mode_r;
  logic [30:0] max_r;
  logic [15:0] esize_r;
  logic [31:0] ssize_r;

  logic [1:0]  state_r, state_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic        payload_r, payload_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        neg_r, neg_nxt;
  logic [30:0] left_r, left_nxt;
  logic        failed_r, failed_nxt;
  logic [31:0] v_r, v_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [4:0]  step_r, step_nxt;

  logic                 out_valid_r;
  lfp_pkg::result_t     out_r;
  lfp_pkg::result_t     res;
  logic                 res_load;

  logic        in_acc;
  logic        cfg_wr;
  logic [15:0] es;
  logic [31:0] pos_inc;
  logic [31:0] acc_new;
  logic        neg_new;
  logic        more;
  logic        fail_now;
  logic [31:0] v_fin;
  logic [31:0] stream_left;
  logic [17:0] trial;

  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_acc    = in_valid && in_ready;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign es        = (esize_r == 16'd0) ? 16'd1 : esize_r;
  assign pos_inc   = pos_r + 32'd1;
  assign trial     = {1'b0, rem_r, quo_r[31]} - {2'b00, es};
  assign stream_left = (pos_r < ssize_r) ? (ssize_r - pos_r) : 32'd0;

  always_comb begin
    acc_new = acc_r;
    neg_new = neg_r;
    more    = in_data_byte[7];
    fail_now = 1'b0;
    case (cnt_r)
      3'd0: begin
        acc_new = {26'd0, in_data_byte[5:0]};
        neg_new = in_data_byte[6];
      end
      3'd1: acc_new = acc_r | {19'd0, in_data_byte[6:0], 6'd0};
      3'd2: acc_new = acc_r | {12'd0, in_data_byte[6:0], 13'd0};
      3'd3: begin
        acc_new  = acc_r | {5'd0, in_data_byte[6:0], 20'd0};
        fail_now = (pos_inc >= ssize_r);
      end
      default: begin
        acc_new = acc_r | {in_data_byte[4:0], 27'd0};
        more    = 1'b0;
      end
    endcase
    v_fin = neg_new ? (32'd0 - acc_new) : acc_new;
  end

  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    payload_nxt = payload_r;
    cnt_nxt     = cnt_r;
    acc_nxt     = acc_r;
    neg_nxt     = neg_r;
    left_nxt    = left_r;
    failed_nxt  = failed_r;
    v_nxt       = v_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    step_nxt    = step_r;
    res_load    = 1'b0;
    res         = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && !failed_r) begin
          if (payload_r) begin
            pos_nxt  = pos_inc;
            left_nxt = left_r - 31'd1;
            if (left_r == 31'd1) begin
              payload_nxt = 1'b0;
            end
            res_load  = 1'b1;
            res.kind  = lfp_pkg::KIND_PAYLOAD;
            res.pbyte = in_data_byte;
            res.last  = (left_r == 31'd1);
          end else if (pos_r >= ssize_r) begin
            failed_nxt = 1'b1;
            res_load   = 1'b1;
            res.kind   = lfp_pkg::KIND_ERROR;
            res.code   = lfp_pkg::ERR_OVERRUN;
            res.last   = 1'b1;
          end else begin
            pos_nxt = pos_inc;
            if (fail_now) begin
              failed_nxt = 1'b1;
              res_load   = 1'b1;
              res.kind   = lfp_pkg::KIND_ERROR;
              res.code   = lfp_pkg::ERR_OVERRUN;
              res.last   = 1'b1;
            end else if (more) begin
              cnt_nxt = cnt_r + 3'd1;
              acc_nxt = acc_new;
              neg_nxt = neg_new;
            end else begin
              cnt_nxt = 3'd0;
              acc_nxt = 32'd0;
              neg_nxt = 1'b0;
              if (!mode_r) begin
                res_load  = 1'b1;
                res.kind  = lfp_pkg::KIND_INT;
                res.value = v_fin;
                res.last  = 1'b1;
              end else begin
                v_nxt     = v_fin;
                state_nxt = ST_CHECK;
              end
            end
          end
        end
      end
      ST_CHECK: begin
        if (v_r[31] || (v_r[30:0] > max_r) || (v_r > stream_left)) begin
          failed_nxt = 1'b1;
          res_load   = 1'b1;
          res.kind   = lfp_pkg::KIND_ERROR;
          res.last   = 1'b1;
          if (v_r[31]) begin
            res.code = lfp_pkg::ERR_NEGATIVE;
          end else if (v_r[30:0] > max_r) begin
            res.code = lfp_pkg::ERR_TOO_LONG;
          end else begin
            res.code = lfp_pkg::ERR_NO_DATA;
          end
          state_nxt = ST_IDLE;
        end else begin
          quo_nxt   = v_r;
          rem_nxt   = 16'd0;
          step_nxt  = 5'd0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        quo_nxt  = {quo_r[30:0], ~trial[17]};
        rem_nxt  = trial[17] ? {rem_r[14:0], quo_r[31]} : trial[15:0];
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd31) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        res_load  = 1'b1;
        res.last  = 1'b1;
        state_nxt = ST_IDLE;
        if (rem_r != 16'd0) begin
          failed_nxt = 1'b1;
          res.kind   = lfp_pkg::KIND_ERROR;
          res.code   = lfp_pkg::ERR_NOT_MULTIPLE;
        end else begin
          res.kind  = lfp_pkg::KIND_HEADER;
          res.value = quo_r;
          res.last  = (v_r == 32'd0);
          if (v_r != 32'd0) begin
            payload_nxt = 1'b1;
            left_nxt    = v_r[30:0];
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= 32'd0;
      payload_r   <= 1'b0;
      cnt_r       <= 3'd0;
      acc_r       <= 32'd0;
      neg_r       <= 1'b0;
      left_r      <= 31'd0;
      failed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pos_r     <= pos_nxt;
      payload_r <= payload_nxt;
      cnt_r     <= cnt_nxt;
      acc_r     <= acc_nxt;
      neg_r     <= neg_nxt;
      left_r    <= left_nxt;
      failed_r  <= failed_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    if (res_load) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      max_r   <= lfp_pkg::MAX_LENGTH_RESET;
      esize_r <= 16'd1;
      ssize_r <= 32'd0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        lfp_pkg::REG_FIELD_MODE:   mode_r  <= pwdata[0];
        lfp_pkg::REG_MAX_LENGTH:   max_r   <= pwdata[30:0];
        lfp_pkg::REG_ELEMENT_SIZE: esize_r <= pwdata[15:0];
        lfp_pkg::REG_STREAM_SIZE:  ssize_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      lfp_pkg::REG_FIELD_MODE:   prdata = {31'd0, mode_r};
      lfp_pkg::REG_MAX_LENGTH:   prdata = {1'b0, max_r};
      lfp_pkg::REG_ELEMENT_SIZE: prdata = {16'd0, esize_r};
      lfp_pkg::REG_STREAM_SIZE:  prdata = ssize_r;
      default:                   prdata = 32'd0;
    endcase
  end

  assign pready           = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_r.kind;
  assign out_value        = signed'(out_r.value);
  assign out_payload_byte = out_r.pbyte;
  assign out_error_code   = out_r.code;
  assign out_last         = out_r.last;

endmodule

/* rtl/lfp_checker.sv */
// Port-level checks for the field parser and their binding to its top level.
module lfp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_result_kind,
  input logic signed [31:0] out_value,
  input logic [7:0]         out_payload_byte,
  input logic [2:0]         out_error_code,
  input logic               out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind) &&
      $stable(out_value) && $stable(out_payload_byte) && $stable(out_last))
    else $error("Result word changed while stalled.");

  a_error_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == lfp_pkg::KIND_ERROR) |->
      out_last && (out_error_code <= lfp_pkg::ERR_OVERRUN) && (out_value == 32'sd0))
    else $error("Malformed error word.");

  a_silent_after_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_result_kind == lfp_pkg::KIND_ERROR) |=> !out_valid)
    else $error("Result issued after an error.");

  a_int_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == lfp_pkg::KIND_INT) |->
      out_last && (out_payload_byte == 8'd0) && (out_error_code == 3'd0))
    else $error("Malformed integer word.");

endmodule

bind length_prefixed_field_parser lfp_checker u_lfp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_result_kind  (out_result_kind),
  .out_value        (out_value),
  .out_payload_byte (out_payload_byte),
  .out_error_code   (out_error_code),
  .out_last         (out_last)
);

/* tb/sv/length_prefixed_field_parser_tb.sv */
// Self-checking testbench for the signed varint and length-prefixed field parser.
`timescale 1ns / 1ps

module length_prefixed_field_parser_tb;

  localparam int IDLE_PCT       = 19;
  localparam int SETTLE_CYCLES  = 48;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TARGET_BYTES   = 1900;
  localparam int ROOM_NEEDED    = 8;

  typedef enum int {
    EXIT_NEGATIVE, EXIT_TOO_LONG, EXIT_NO_DATA, EXIT_NOT_MULTIPLE, EXIT_OVERRUN,
    EXIT_FOURTH_BYTE
  } exit_case_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_data_byte = 8'd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_result_kind;
  logic signed [31:0] out_value;
  logic [7:0]         out_payload_byte;
  logic [2:0]         out_error_code;
  logic               out_last;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = 4'd0;
  logic [31:0]        pwdata = 32'd0;
  logic [31:0]        prdata;
  logic               pready;

  // Register mirror.
  logic        mode_sel;
  logic [30:0] length_cap;
  logic [15:0] elem_bytes;
  logic [31:0] stream_lim;

  // Decoder state mirror.
  logic [31:0] pos_count;
  logic        in_payload;
  logic [2:0]  prefix_count;
  logic [31:0] magnitude;
  logic        sign_flag;
  logic [30:0] bytes_left;
  logic        halted;

  lfp_pkg::result_t expected_words[$];
  lfp_pkg::result_t want_word;
  int          mismatches = 0;
  int          words_checked = 0;
  int          bytes_sent = 0;
  int          quiet_cycles = 0;
  int          hold_count = 0;
  logic        hold_request = 1'b0;
  logic        steady = 1'b0;
  exit_case_t  exit_case;

  length_prefixed_field_parser dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data_byte(in_data_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_result_kind(out_result_kind),
    .out_value(out_value), .out_payload_byte(out_payload_byte),
    .out_error_code(out_error_code), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns, word %0d: %s", $time, words_checked, msg);
    mismatches++;
  endtask

  task automatic post_error(input logic [2:0] code);
    lfp_pkg::result_t r;
    r = '0;
    r.kind = lfp_pkg::KIND_ERROR;
    r.code = code;
    r.last = 1'b1;
    halted = 1'b1;
    expected_words.push_back(r);
  endtask

  task automatic decode_stream_byte(input logic [7:0] b);
    lfp_pkg::result_t r;
    logic        more;
    logic [31:0] v;
    logic [31:0] es;
    logic [31:0] avail;
    if (halted) return;
    r = '0;
    if (in_payload) begin
      pos_count++;
      bytes_left = bytes_left - 31'd1;
      if (bytes_left == 31'd0) in_payload = 1'b0;
      r.kind = lfp_pkg::KIND_PAYLOAD;
      r.pbyte = b;
      r.last = (bytes_left == 31'd0);
      expected_words.push_back(r);
      return;
    end
    if (pos_count >= stream_lim) begin
      post_error(lfp_pkg::ERR_OVERRUN);
      return;
    end
    pos_count++;
    more = b[7];
    case (prefix_count)
      3'd0: begin
        magnitude = {26'd0, b[5:0]};
        sign_flag = b[6];
      end
      3'd1: magnitude |= 32'(b[6:0]) << 6;
      3'd2: magnitude |= 32'(b[6:0]) << 13;
      3'd3: begin
        magnitude |= 32'(b[6:0]) << 20;
        // Quirk: after the fourth prefix byte at least one more byte must remain.
        if (pos_count >= stream_lim) begin
          post_error(lfp_pkg::ERR_OVERRUN);
          return;
        end
      end
      default: begin
        magnitude |= 32'(b[6:0]) << 27;
        more = 1'b0;
      end
    endcase
    if (more) begin
      prefix_count++;
      return;
    end
    v = sign_flag ? (32'd0 - magnitude) : magnitude;
    es = (elem_bytes == 16'd0) ? 32'd1 : {16'd0, elem_bytes};
    prefix_count = 3'd0;
    magnitude = 32'd0;
    sign_flag = 1'b0;
    avail = (pos_count < stream_lim) ? stream_lim - pos_count : 32'd0;
    if (!mode_sel) begin
      r.kind = lfp_pkg::KIND_INT;
      r.value = v;
      r.last = 1'b1;
      expected_words.push_back(r);
    end else if (v[31]) begin
      post_error(lfp_pkg::ERR_NEGATIVE);
    end else if (v > {1'b0, length_cap}) begin
      post_error(lfp_pkg::ERR_TOO_LONG);
    end else if (v > avail) begin
      post_error(lfp_pkg::ERR_NO_DATA);
    end else if ((v % es) != 32'd0) begin
      post_error(lfp_pkg::ERR_NOT_MULTIPLE);
    end else begin
      if (v != 32'd0) begin
        in_payload = 1'b1;
        bytes_left = v[30:0];
      end
      r.kind = lfp_pkg::KIND_HEADER;
      r.value = v / es;
      r.last = (v == 32'd0);
      expected_words.push_back(r);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    decode_stream_byte(b);
    bytes_sent++;
  endtask

  task automatic send_varint(input logic [33:0] mag, input logic neg, input int nbytes);
    logic [7:0] b;
    for (int k = 0; k < nbytes; k++) begin
      if (k == 0) b = {1'(nbytes > 1), neg, mag[5:0]};
      else if (k < 4) b = {1'(k < nbytes - 1), mag[6 + 7 * (k - 1) +: 7]};
      else b = {1'($urandom), mag[33:27]};
      send_byte(b);
    end
  endtask

  task automatic send_buffer(input logic [30:0] len, input int nbytes, input logic neg);
    send_varint({3'd0, len}, neg, nbytes);
    repeat (len) send_byte(8'($urandom));
  endtask

  function automatic int prefix_len(input logic [33:0] m);
    int n = 1;
    while (n < 5 && (m >> (6 + 7 * (n - 1))) != 0) n++;
    return n;
  endfunction

  task automatic write_register(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      lfp_pkg::REG_FIELD_MODE:   mode_sel = val[0];
      lfp_pkg::REG_MAX_LENGTH:   length_cap = val[30:0];
      lfp_pkg::REG_ELEMENT_SIZE: elem_bytes = val[15:0];
      lfp_pkg::REG_STREAM_SIZE:  stream_lim = val;
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_integer_fields();
    settle();
    write_register(lfp_pkg::REG_FIELD_MODE, 32'd0);
    write_register(lfp_pkg::REG_MAX_LENGTH, 32'd0);
    write_register(lfp_pkg::REG_ELEMENT_SIZE, 32'd0);
    write_register(lfp_pkg::REG_STREAM_SIZE, 32'hFFFF_FFFF);
    send_varint(34'd0, 1'b0, 1);
    send_varint(34'd63, 1'b0, 1);
    send_varint(34'd63, 1'b1, 1);
    send_varint(34'd0, 1'b1, 1);
    send_varint(34'h3_FFFF_FFFF, 1'b0, 5);
    send_varint(34'h0_7FFF_FFFF, 1'b0, 5);
    send_varint(34'h0_8000_0000, 1'b1, 5);
    send_varint(34'd5, 1'b0, 3);
    // Only bits above the 32-bit range are set, so the value folds to zero.
    send_varint(34'h3_0000_0000, 1'b1, 5);
  endtask

  task automatic test_buffer_fields();
    settle();
    write_register(lfp_pkg::REG_FIELD_MODE, 32'd1);
    write_register(lfp_pkg::REG_MAX_LENGTH, 32'h7FFF_FFFF);
    write_register(lfp_pkg::REG_ELEMENT_SIZE, 32'd1);
    write_register(lfp_pkg::REG_STREAM_SIZE, 32'hFFFF_FFFF);
    send_buffer(31'd0, 1, 1'b0);
    send_buffer(31'd0, 1, 1'b1);
    send_buffer(31'd3, 1, 1'b0);
    send_buffer(31'd5, 3, 1'b0);
    settle();
    write_register(lfp_pkg::REG_ELEMENT_SIZE, 32'd0);
    send_buffer(31'd2, 1, 1'b0);
    settle();
    write_register(lfp_pkg::REG_ELEMENT_SIZE, 32'd65535);
    send_buffer(31'd0, 1, 1'b0);
    // Length equal to both the cap and the bytes left in the stream.
    settle();
    write_register(lfp_pkg::REG_ELEMENT_SIZE, 32'd3);
    write_register(lfp_pkg::REG_MAX_LENGTH, 32'd6);
    write_register(lfp_pkg::REG_STREAM_SIZE, pos_count + 32'd7);
    send_buffer(31'd6, 1, 1'b0);
    settle();
    write_register(lfp_pkg::REG_MAX_LENGTH, 32'd0);
    write_register(lfp_pkg::REG_STREAM_SIZE, 32'hFFFF_FFFF);
    write_register(lfp_pkg::REG_ELEMENT_SIZE, 32'd1);
    send_buffer(31'd0, 2, 1'b0);
  endtask

  task automatic test_backpressure();
    settle();
    write_register(lfp_pkg::REG_FIELD_MODE, 32'd0);
    hold_request = 1'b1;
    repeat (24) send_byte({1'b0, 7'($urandom)});
  endtask

  task automatic test_random_fields();
    int          round = 0;
    int          start;
    int          budget;
    longint      bound;
    logic [31:0] es_eff;
    logic [30:0] len;
    logic [31:0] pick;
    while (bytes_sent < TARGET_BYTES) begin
      settle();
      steady = (round >= 8 && round < 12);
      write_register(lfp_pkg::REG_FIELD_MODE, 32'($urandom_range(0, 1)));
      pick = $urandom_range(0, 3);
      case (pick)
        0: write_register(lfp_pkg::REG_MAX_LENGTH, 32'h7FFF_FFFF);
        1: write_register(lfp_pkg::REG_MAX_LENGTH, $urandom & 32'h7FFF_FFFF);
        2: write_register(lfp_pkg::REG_MAX_LENGTH, $urandom_range(0, 64));
        default: write_register(lfp_pkg::REG_MAX_LENGTH, 32'd0);
      endcase
      pick = $urandom_range(0, 9);
      if (pick == 0) write_register(lfp_pkg::REG_ELEMENT_SIZE, 32'd0);
      else if (pick == 1) write_register(lfp_pkg::REG_ELEMENT_SIZE, 32'd65535);
      else if (pick < 5) write_register(lfp_pkg::REG_ELEMENT_SIZE, 32'd1);
      else write_register(lfp_pkg::REG_ELEMENT_SIZE, $urandom_range(1, 8));
      if ($urandom_range(0, 1) == 0)
        write_register(lfp_pkg::REG_STREAM_SIZE, 32'hFFFF_FFFF);
      else
        write_register(lfp_pkg::REG_STREAM_SIZE, pos_count + $urandom_range(20, 200));
      start = bytes_sent;
      budget = $urandom_range(30, 90);
      while (bytes_sent - start < budget && stream_lim - pos_count >= ROOM_NEEDED) begin
        if (mode_sel) begin
          es_eff = (elem_bytes == 16'd0) ? 32'd1 : {16'd0, elem_bytes};
          bound = 48;
          if (length_cap < bound) bound = length_cap;
          if (longint'(stream_lim - pos_count) - 5 < bound)
            bound = longint'(stream_lim - pos_count) - 5;
          len = 31'($urandom_range(0, 32'(bound / es_eff)) * es_eff);
          send_buffer(len, $urandom_range(prefix_len({3'd0, len}), 5),
                      len == 0 && $urandom_range(0, 3) == 0);
        end else if ($urandom_range(0, 99) < 15) begin
          send_byte(8'($urandom));
        end else begin
          send_varint({2'($urandom), 32'($urandom)}, 1'($urandom), $urandom_range(1, 5));
        end
      end
      // Close a prefix left open by raw bytes so the next round starts aligned.
      if (prefix_count != 3'd0) send_byte(8'h00);
      round++;
    end
    steady = 1'b0;
  endtask

  task automatic test_error_exit();
    logic [30:0] cap;
    settle();
    exit_case = exit_case_t'($urandom_range(0, 5));
    case (exit_case)
      EXIT_NEGATIVE: begin
        write_register(lfp_pkg::REG_FIELD_MODE, 32'd1);
        write_register(lfp_pkg::REG_MAX_LENGTH, 32'h7FFF_FFFF);
        write_register(lfp_pkg::REG_STREAM_SIZE, 32'hFFFF_FFFF);
        send_varint(34'($urandom_range(1, 63)), 1'b1, 1);
      end
      EXIT_TOO_LONG: begin
        cap = 31'($urandom_range(0, 100));
        write_register(lfp_pkg::REG_FIELD_MODE, 32'd1);
        write_register(lfp_pkg::REG_MAX_LENGTH, {1'b0, cap});
        write_register(lfp_pkg::REG_STREAM_SIZE, 32'hFFFF_FFFF);
        send_varint({3'd0, cap} + 34'($urandom_range(1, 20)), 1'b0, 2);
      end
      EXIT_NO_DATA: begin
        write_register(lfp_pkg::REG_FIELD_MODE, 32'd1);
        write_register(lfp_pkg::REG_MAX_LENGTH, 32'h7FFF_FFFF);
        write_register(lfp_pkg::REG_STREAM_SIZE, pos_count + 32'd4);
        send_varint(34'd10, 1'b0, 1);
      end
      EXIT_NOT_MULTIPLE: begin
        write_register(lfp_pkg::REG_FIELD_MODE, 32'd1);
        write_register(lfp_pkg::REG_MAX_LENGTH, 32'h7FFF_FFFF);
        write_register(lfp_pkg::REG_ELEMENT_SIZE, 32'd65535);
        write_register(lfp_pkg::REG_STREAM_SIZE, 32'hFFFF_FFFF);
        send_varint(34'd100, 1'b0, 2);
      end
      EXIT_OVERRUN: begin
        write_register(lfp_pkg::REG_STREAM_SIZE, pos_count);
        send_byte(8'($urandom));
      end
      default: begin
        write_register(lfp_pkg::REG_STREAM_SIZE, pos_count + 32'd4);
        send_varint({2'($urandom), 32'($urandom)}, 1'($urandom), 5);
      end
    endcase
    // The block is halted now and drops everything it takes.
    repeat (6) send_byte(8'($urandom));
  endtask

  always @(posedge clk) begin
    if (hold_request) begin
      out_ready <= 1'b0;
      hold_count++;
      if (hold_count == HOLD_CYCLES) begin
        hold_count = 0;
        hold_request = 1'b0;
      end
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word of kind %0d", out_result_kind));
      end else begin
        want_word = expected_words.pop_front();
        if (out_result_kind !== want_word.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", out_result_kind, want_word.kind));
        if (out_value !== want_word.value)
          report_mismatch($sformatf("value %0h, expected %0h", out_value, want_word.value));
        if (out_payload_byte !== want_word.pbyte)
          report_mismatch($sformatf("payload %0h, expected %0h", out_payload_byte,
                                    want_word.pbyte));
        if (out_error_code !== want_word.code)
          report_mismatch($sformatf("error code %0d, expected %0d", out_error_code,
                                    want_word.code));
        if (out_last !== want_word.last)
          report_mismatch($sformatf("last %0b, expected %0b", out_last, want_word.last));
        words_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("** length_prefixed_field_parser: FAILED **");
      $finish;
    end
  end

  initial begin
    mode_sel = 1'b0;
    length_cap = lfp_pkg::MAX_LENGTH_RESET;
    elem_bytes = 16'd1;
    stream_lim = 32'd0;
    pos_count = 32'd0;
    in_payload = 1'b0;
    prefix_count = 3'd0;
    magnitude = 32'd0;
    sign_flag = 1'b0;
    bytes_left = 31'd0;
    halted = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_integer_fields();
    test_buffer_fields();
    test_backpressure();
    test_random_fields();
    test_error_exit();
    settle();
    $display("Sent %0d stream bytes and checked %0d result words over integer,", bytes_sent,
             words_checked);
    $display("buffer, back-pressure and random phases, ending on the %s case.",
             exit_case.name());
    if (mismatches == 0) begin
      $display("** length_prefixed_field_parser: PASSED **");
    end else begin
      $display("** length_prefixed_field_parser: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/lfp_pkg.sv
rtl/length_prefixed_field_parser.sv
rtl/lfp_checker.sv
tb/sv/length_prefixed_field_parser_tb.sv
